// ----- sv/fds_pkg.sv -----
// Shared types and constants of the firmware download sequencer.
package fds_pkg;

    localparam int unsigned CHUNK_MAX = 16;
    localparam int unsigned CNT_W     = 5;

    localparam logic [7:0] RID_MODE_RESP   = 8'he4;
    localparam logic [7:0] RID_STATUS_RESP = 8'he6;
    localparam logic [7:0] RID_WRITE_RESP  = 8'he8;

    localparam logic [7:0] MODE_UPGRADE     = 8'd1;
    localparam logic [7:0] MODE_APPLICATION = 8'd3;

    localparam logic [31:0] FLAG_LAUNCH_BOOTLOADER = 32'h0000_0002;
    localparam logic [31:0] FLAG_APP_VALID         = 32'h0000_0010;
    localparam logic [31:0] FLAG_ERROR             = 32'h4000_0000;

    localparam logic [15:0] IMAGE_WORDS_RESET   = 16'd256;
    localparam logic [31:0] TIMEOUT_TICKS_RESET = 32'd240000000;

    localparam logic OP_RESPONSE = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    typedef enum logic [2:0] {
        PH_WAIT_STATUS = 3'd0,
        PH_SET_MODE    = 3'd1,
        PH_SENDING     = 3'd2,
        PH_WAIT_DONE   = 3'd3,
        PH_LAUNCHING   = 3'd4,
        PH_FINISHED    = 3'd5
    } fds_phase_t;

    typedef enum logic [1:0] {
        REQ_NONE   = 2'd0,
        REQ_MODE   = 2'd1,
        REQ_WRITE  = 2'd2,
        REQ_LAUNCH = 2'd3
    } fds_req_t;

    typedef enum logic [1:0] {
        OUT_OK      = 2'd0,
        OUT_DEVICE  = 2'd1,
        OUT_TIMEOUT = 2'd2
    } fds_outcome_t;

    typedef enum logic {
        REG_IMAGE_WORDS   = 1'b0,
        REG_TIMEOUT_TICKS = 1'b1
    } fds_reg_idx_t;

    typedef struct packed {
        logic [15:0] image_words;
        logic [31:0] timeout_ticks;
    } fds_cfg_t;

    typedef struct packed {
        logic        operation;
        logic [7:0]  report_id;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [31:0] status_word;
        logic [31:0] error_word;
    } fds_item_t;

    typedef struct packed {
        logic             valid;
        fds_req_t         request_kind;
        logic [15:0]      word_offset;
        logic [CNT_W-1:0] word_count;
        logic             finished;
        fds_outcome_t     outcome;
        logic [15:0]      ignored_count;
    } fds_result_t;

endpackage

// ----- sv/fds_cfg.sv -----
// Configuration register file behind the APB-style port.
module fds_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output fds_pkg::fds_cfg_t cfg
);
    import fds_pkg::*;

    logic [15:0] image_words_reg;
    logic [31:0] timeout_ticks_reg;
    logic        wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_words_reg   <= IMAGE_WORDS_RESET;
            timeout_ticks_reg <= TIMEOUT_TICKS_RESET;
        end
        else if (wr_en)
        begin
            unique case (fds_reg_idx_t'(paddr[2]))
                REG_IMAGE_WORDS:   image_words_reg   <= pwdata[15:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (fds_reg_idx_t'(paddr[2]))
            REG_IMAGE_WORDS:   prdata = {16'd0, image_words_reg};
            REG_TIMEOUT_TICKS: prdata = timeout_ticks_reg;
        endcase
    end

    assign cfg.image_words   = image_words_reg;
    assign cfg.timeout_ticks = timeout_ticks_reg;

endmodule

// ----- sv/fds_engine.sv -----
// Download phase state and the per-transaction next-state and result logic.
module fds_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  fds_pkg::fds_item_t   item,
    input  fds_pkg::fds_cfg_t    cfg,
    output fds_pkg::fds_result_t result
);
    import fds_pkg::*;

    fds_phase_t       phase_reg, phase_next;
    logic [15:0]      next_word_reg, next_word_next;
    logic [CNT_W-1:0] chunk_words_reg, chunk_words_next;
    logic [31:0]      elapsed_reg, elapsed_next;
    logic [15:0]      ignored_reg, ignored_next;
    fds_outcome_t     outcome_reg, outcome_next;

    logic [31:0]      elapsed_inc;
    logic [15:0]      advanced_word;
    logic [CNT_W-1:0] first_chunk;
    logic [CNT_W-1:0] later_chunk;

    function automatic logic [CNT_W-1:0] pick_chunk(input logic [15:0] image,
                                                    input logic [15:0] offset);
        logic [15:0] left;
        left = (image > offset) ? image - offset : 16'd0;
        if (left > 16'(CHUNK_MAX))
            return CNT_W'(CHUNK_MAX);
        return left[CNT_W-1:0];
    endfunction

    assign elapsed_inc   = (elapsed_reg != '1) ? elapsed_reg + 32'd1 : elapsed_reg;
    assign advanced_word = next_word_reg + 16'(chunk_words_reg);
    assign first_chunk   = pick_chunk(cfg.image_words, 16'd0);
    assign later_chunk   = pick_chunk(cfg.image_words, advanced_word);

    always_comb
    begin
        phase_next          = phase_reg;
        next_word_next      = next_word_reg;
        chunk_words_next    = chunk_words_reg;
        elapsed_next        = elapsed_reg;
        ignored_next        = ignored_reg;
        outcome_next        = outcome_reg;
        result.valid        = 1'b0;
        result.request_kind = REQ_NONE;
        result.word_offset  = '0;
        result.word_count   = '0;

        if (item.operation == OP_TICK)
        begin
            if (phase_reg != PH_FINISHED)
            begin
                elapsed_next = elapsed_inc;
                if (elapsed_inc >= cfg.timeout_ticks)
                begin
                    outcome_next = OUT_TIMEOUT;
                    phase_next   = PH_FINISHED;
                    result.valid = 1'b1;
                end
            end
        end
        else
        begin
            result.valid = 1'b1;
            priority if (phase_reg == PH_WAIT_STATUS && item.report_id == RID_STATUS_RESP)
            begin
                if ((item.status_word & FLAG_LAUNCH_BOOTLOADER) != '0)
                begin
                    result.request_kind = REQ_MODE;
                    phase_next          = PH_SET_MODE;
                end
                else
                begin
                    outcome_next = OUT_DEVICE;
                    phase_next   = PH_FINISHED;
                end
            end
            else if (phase_reg == PH_SET_MODE && item.report_id == RID_MODE_RESP)
            begin
                if (item.first_byte == MODE_UPGRADE && item.second_byte == 8'd0)
                begin
                    next_word_next      = '0;
                    chunk_words_next    = first_chunk;
                    result.request_kind = REQ_WRITE;
                    result.word_count   = first_chunk;
                    phase_next          = PH_SENDING;
                end
                else
                begin
                    outcome_next = OUT_DEVICE;
                    phase_next   = PH_FINISHED;
                end
            end
            else if (phase_reg == PH_SENDING && item.report_id == RID_WRITE_RESP)
            begin
                if (item.first_byte == 8'd0)
                begin
                    next_word_next = advanced_word;
                    if (advanced_word >= cfg.image_words)
                        phase_next = PH_WAIT_DONE;
                    else
                    begin
                        chunk_words_next    = later_chunk;
                        result.request_kind = REQ_WRITE;
                        result.word_offset  = advanced_word;
                        result.word_count   = later_chunk;
                    end
                end
                else
                begin
                    outcome_next = OUT_DEVICE;
                    phase_next   = PH_FINISHED;
                end
            end
            else if (phase_reg == PH_WAIT_DONE && item.report_id == RID_STATUS_RESP)
            begin
                if ((item.status_word & FLAG_APP_VALID) != '0 &&
                    (item.status_word & FLAG_ERROR) == '0 && item.error_word == '0)
                begin
                    result.request_kind = REQ_LAUNCH;
                    outcome_next        = OUT_OK;
                    phase_next          = PH_LAUNCHING;
                end
                else
                begin
                    outcome_next = OUT_DEVICE;
                    phase_next   = PH_FINISHED;
                end
            end
            else if (phase_reg == PH_LAUNCHING && item.report_id == RID_MODE_RESP)
            begin
                outcome_next = (item.first_byte == MODE_APPLICATION && item.second_byte == 8'd0)
                               ? OUT_OK : OUT_DEVICE;
                phase_next   = PH_FINISHED;
            end
            else
            begin
                // wrong phase, finished or unexpected id: count it, saturating
                if (ignored_reg != '1)
                    ignored_next = ignored_reg + 16'd1;
            end
        end

        result.finished      = (phase_next == PH_FINISHED);
        result.outcome       = outcome_next;
        result.ignored_count = ignored_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_WAIT_STATUS;
            next_word_reg   <= '0;
            chunk_words_reg <= '0;
            elapsed_reg     <= '0;
            ignored_reg     <= '0;
            outcome_reg     <= OUT_OK;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            next_word_reg   <= next_word_next;
            chunk_words_reg <= chunk_words_next;
            elapsed_reg     <= elapsed_next;
            ignored_reg     <= ignored_next;
            outcome_reg     <= outcome_next;
        end
    end

endmodule

// ----- sv/firmware_download_sequencer.sv -----
// Top level of the firmware download sequencer: input and result registers.
//
// Usage: the host feeds received response messages and time ticks on the
// input channel (in_valid / in_stall, operation selects message or tick).
// Each message yields one transaction on the output channel; a tick yields
// one only when it trips the timeout. The output carries the request to
// send next (upgrade mode, write with word offset and count, launch) plus
// finished, outcome and the saturating ignored-response count.
// The accepted input is loaded into the input register, then the phase logic
// runs into the result register once that register is free or being drained.
// Throughput: one transaction per cycle while out_stall holds no pending
// result, set by the single phase-update step that reads and writes the phase state.
// While out_stall holds a pending result, the input register fills and
// then in_stall rises until the result is taken; nothing is dropped.
// Configuration (image_words at 0x0, timeout_ticks at 0x4) is to be written by the user
// through the APB-style port while no transaction is in flight; the block does not check it.
// Reset: phase returns to wait-for-status, counters and outcome clear,
// both channels empty, registers take their reset values.
module firmware_download_sequencer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  logic [7:0]            report_id,
    input  logic [7:0]            first_byte,
    input  logic [7:0]            second_byte,
    input  logic [31:0]           status_word,
    input  logic [31:0]           error_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            request_kind,
    output logic [15:0]           word_offset,
    output logic [fds_pkg::CNT_W-1:0] word_count,
    output logic                  finished,
    output logic [1:0]            outcome,
    output logic [15:0]           ignored_count
);
    import fds_pkg::*;

    fds_cfg_t    cfg;
    fds_item_t   item_reg;
    logic        item_valid_reg;
    fds_result_t result;
    fds_result_t out_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        step;
    logic        in_accept;

    assign pready = 1'b1;

    fds_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // result register free, or being drained this cycle
    assign advance   = !out_valid_reg || !out_stall;
    assign step      = item_valid_reg && advance;
    assign in_stall  = item_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_accept)
            item_valid_reg <= 1'b1;
        else if (advance)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.operation   <= operation;
            item_reg.report_id   <= report_id;
            item_reg.first_byte  <= first_byte;
            item_reg.second_byte <= second_byte;
            item_reg.status_word <= status_word;
            item_reg.error_word  <= error_word;
        end
    end

    fds_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= step && result.valid;
    end

    always_ff @(posedge clk)
    begin
        if (step && result.valid)
            out_reg <= result;
    end

    assign out_valid     = out_valid_reg;
    assign request_kind  = out_reg.request_kind;
    assign word_offset   = out_reg.word_offset;
    assign word_count    = out_reg.word_count;
    assign finished      = out_reg.finished;
    assign outcome       = out_reg.outcome;
    assign ignored_count = out_reg.ignored_count;

`ifndef SYNTHESIS
    a_finish_no_request: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished |-> request_kind == REQ_NONE)
        else $error("request issued together with finish");

    a_count_only_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && request_kind != REQ_WRITE |-> word_count == '0 && word_offset == '0)
        else $error("word offset or count on a non-write result");

    a_timeout_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && outcome == OUT_TIMEOUT |-> finished)
        else $error("timeout outcome without finish");

    a_write_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && request_kind == REQ_WRITE |-> word_count <= CNT_W'(CHUNK_MAX))
        else $error("write count exceeds chunk size");
`endif

endmodule
